[rtl/pfr_pkg.sv]
// Package with the shared types, constants and CRC function of the PPP frame receiver.
`default_nettype none
package pfr_pkg;

    localparam int COUNT_BITS = 13;
    localparam int CFG_BITS   = 12;
    localparam int CMP_BITS   = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;

    localparam logic [7:0]  FLAG_BYTE     = 8'h7E;
    localparam logic [7:0]  ADDR_BYTE     = 8'hFF;
    localparam logic [7:0]  CTRL_BYTE     = 8'h03;
    localparam int          MIN_FRAME_LEN = 8;
    localparam logic [15:0] CRC_POLY_REFL = 16'h8408;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_XOR_OUT   = 16'hFFFF;
    localparam logic [CFG_BITS-1:0] MAX_PAYLOAD_RESET = CFG_BITS'(1500);
    localparam logic [CFG_BITS-1:0] LENGTH_MAX        = {CFG_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX       = {COUNT_BITS{1'b1}};

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_SHORT = 3'd1,
        ST_BAD_FLAG  = 3'd2,
        ST_BAD_HDR   = 3'd3,
        ST_TOO_LONG  = 3'd4,
        ST_BAD_FCS   = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_frame;
    } t_item;

    typedef struct packed {
        logic                kind;
        logic [7:0]          payload_byte;
        t_status             status;
        logic [15:0]         protocol;
        logic [15:0]         fcs;
        logic [CFG_BITS-1:0] length;
    } t_result;

    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REFL;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

[rtl/ppp_frame_receiver_fcs16_top.sv]
// Top level of the PPP frame receiver with FCS-16 check.
//
//   Channel  Direction  Handshake                  Content
//   in       sink       i_in_valid / o_in_ready    i_rx_byte, i_end_of_frame
//   out      source     o_out_valid / i_out_ready  result kind, payload byte, status, fields
//   cfg      sink       i_cfg_valid / o_cfg_ready  i_cfg_max_payload
//
// One byte is taken in every cycle while o_in_ready is high; its result passes through the input
// register and the frame logic into the result register, from which it can leave when taken.
// A byte causes at most one result, so the rate is set by the single frame-state update.
// When the result register is full and not taken, a byte in the input register holds and
// o_in_ready falls. The synchronous reset clears all frame state and sets max_payload to 1500.
`default_nettype none
module ppp_frame_receiver_fcs16_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [7:0]                   i_rx_byte,
    input  wire logic                         i_end_of_frame,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic                              o_result_kind,
    output logic [7:0]                        o_payload_byte,
    output logic [2:0]                        o_frame_status,
    output logic [15:0]                       o_protocol_field,
    output logic [15:0]                       o_received_fcs,
    output logic [pfr_pkg::CFG_BITS-1:0]      o_payload_length,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [pfr_pkg::CFG_BITS-1:0] i_cfg_max_payload
);

    logic [pfr_pkg::CFG_BITS-1:0] r_max_payload;
    pfr_pkg::t_item               in_item;
    pfr_pkg::t_item               stage_item;
    logic                         stage_valid;
    logic                         out_free;
    logic                         fire;
    logic                         res_valid;
    pfr_pkg::t_result             core_result;
    pfr_pkg::t_result             out_result;

    assign o_cfg_ready          = 1'b1;
    assign in_item.rx_byte      = i_rx_byte;
    assign in_item.end_of_frame = i_end_of_frame;
    assign fire                 = stage_valid && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= pfr_pkg::MAX_PAYLOAD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_payload <= i_cfg_max_payload;
        end
    end

    pfr_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .i_take  (fire),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    pfr_frame_core u_frame_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_item        (stage_item),
        .i_max_payload (r_max_payload),
        .o_res_valid   (res_valid),
        .o_result      (core_result)
    );

    pfr_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (res_valid),
        .i_result (core_result),
        .i_ready  (i_out_ready),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_result_kind    = out_result.kind;
    assign o_payload_byte   = out_result.payload_byte;
    assign o_frame_status   = out_result.status;
    assign o_protocol_field = out_result.protocol;
    assign o_received_fcs   = out_result.fcs;
    assign o_payload_length = out_result.length;

    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("Input stalled without a blocked result.");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_frame_status <= 3'(pfr_pkg::ST_BAD_FCS)))
        else $error("Frame status code out of range.");

    a_payload_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == pfr_pkg::KIND_PAYLOAD) |->
        (o_frame_status == 3'(pfr_pkg::ST_OK) && o_protocol_field == 16'h0000 &&
         o_received_fcs == 16'h0000 && o_payload_length == '0))
        else $error("Payload result carries status fields.");

    a_status_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == pfr_pkg::KIND_STATUS) |-> (o_payload_byte == 8'h00))
        else $error("Status result carries a payload byte.");

endmodule
`default_nettype wire

[rtl/pfr_in_stage.sv]
// Input register that holds one received byte until the frame logic takes it.
`default_nettype none
module pfr_in_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire pfr_pkg::t_item i_item,
    input  wire logic          i_take,
    output logic               o_valid,
    output pfr_pkg::t_item     o_item
);

    logic           r_valid;
    pfr_pkg::t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule
`default_nettype wire

[rtl/pfr_frame_core.sv]
// Frame state, header checks, FCS-16 accumulation and status decision for each byte.
`default_nettype none
module pfr_frame_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_fire,
    input  wire pfr_pkg::t_item                i_item,
    input  wire logic [pfr_pkg::CFG_BITS-1:0]  i_max_payload,
    output logic                               o_res_valid,
    output pfr_pkg::t_result                   o_result
);

    logic [pfr_pkg::COUNT_BITS-1:0] r_index, n_index;
    logic [15:0]                    r_crc, n_crc;
    logic [7:0]                     r_tail0, n_tail0;
    logic [7:0]                     r_tail1, n_tail1;
    logic [15:0]                    r_proto, n_proto;
    logic                           r_flag_ok, n_flag_ok;
    logic                           r_hdr_ok, n_hdr_ok;
    logic [pfr_pkg::COUNT_BITS-1:0] r_pcount, n_pcount;

    always_comb begin
        logic [pfr_pkg::CMP_BITS-1:0] pc_ext;
        logic [pfr_pkg::CMP_BITS-1:0] mp_ext;
        logic [15:0]                  fcs_rx;
        pfr_pkg::t_status             status;
        pc_ext      = pfr_pkg::CMP_BITS'(r_pcount);
        mp_ext      = pfr_pkg::CMP_BITS'(i_max_payload);
        fcs_rx      = {r_tail1, r_tail0};
        status      = pfr_pkg::ST_OK;
        n_index     = r_index;
        n_crc       = r_crc;
        n_tail0     = r_tail0;
        n_tail1     = r_tail1;
        n_proto     = r_proto;
        n_flag_ok   = r_flag_ok;
        n_hdr_ok    = r_hdr_ok;
        n_pcount    = r_pcount;
        o_res_valid = 1'b0;
        o_result    = '0;
        if (i_fire) begin
            if (i_item.end_of_frame) begin
                if (r_index < pfr_pkg::COUNT_BITS'(pfr_pkg::MIN_FRAME_LEN - 1)) begin
                    status = pfr_pkg::ST_TOO_SHORT;
                end else if (!r_flag_ok || i_item.rx_byte != pfr_pkg::FLAG_BYTE) begin
                    status = pfr_pkg::ST_BAD_FLAG;
                end else if (!r_hdr_ok) begin
                    status = pfr_pkg::ST_BAD_HDR;
                end else if (pc_ext > mp_ext) begin
                    status = pfr_pkg::ST_TOO_LONG;
                end else if ((r_crc ^ pfr_pkg::CRC_XOR_OUT) != fcs_rx) begin
                    status = pfr_pkg::ST_BAD_FCS;
                end
                o_res_valid       = 1'b1;
                o_result.kind     = pfr_pkg::KIND_STATUS;
                o_result.status   = status;
                o_result.protocol = r_proto;
                o_result.fcs      = fcs_rx;
                if (pc_ext > pfr_pkg::CMP_BITS'(pfr_pkg::LENGTH_MAX)) begin
                    o_result.length = pfr_pkg::LENGTH_MAX;
                end else begin
                    o_result.length = pc_ext[pfr_pkg::CFG_BITS-1:0];
                end
                n_index   = '0;
                n_crc     = pfr_pkg::CRC_INIT;
                n_tail0   = '0;
                n_tail1   = '0;
                n_proto   = '0;
                n_flag_ok = 1'b0;
                n_hdr_ok  = 1'b0;
                n_pcount  = '0;
            end else begin
                if (r_index == pfr_pkg::COUNT_BITS'(0)) begin
                    n_flag_ok = (i_item.rx_byte == pfr_pkg::FLAG_BYTE);
                end else if (r_index == pfr_pkg::COUNT_BITS'(1)) begin
                    n_hdr_ok = (i_item.rx_byte == pfr_pkg::ADDR_BYTE);
                end else if (r_index == pfr_pkg::COUNT_BITS'(2)) begin
                    n_hdr_ok = r_hdr_ok && (i_item.rx_byte == pfr_pkg::CTRL_BYTE);
                end else if (r_index == pfr_pkg::COUNT_BITS'(3)) begin
                    n_proto = {i_item.rx_byte, 8'h00};
                end else if (r_index == pfr_pkg::COUNT_BITS'(4)) begin
                    n_proto = {r_proto[15:8], i_item.rx_byte};
                end
                if (r_index >= pfr_pkg::COUNT_BITS'(3)) begin
                    n_crc = pfr_pkg::crc_fold(r_crc, r_tail0);
                    if (r_index >= pfr_pkg::COUNT_BITS'(7)) begin
                        if (pc_ext < mp_ext) begin
                            o_res_valid           = 1'b1;
                            o_result.kind         = pfr_pkg::KIND_PAYLOAD;
                            o_result.payload_byte = r_tail0;
                        end
                        if (r_pcount != pfr_pkg::COUNT_MAX) begin
                            n_pcount = r_pcount + 1'b1;
                        end
                    end
                end
                n_tail0 = r_tail1;
                n_tail1 = i_item.rx_byte;
                if (r_index != pfr_pkg::COUNT_MAX) begin
                    n_index = r_index + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index   <= '0;
            r_crc     <= pfr_pkg::CRC_INIT;
            r_tail0   <= '0;
            r_tail1   <= '0;
            r_proto   <= '0;
            r_flag_ok <= 1'b0;
            r_hdr_ok  <= 1'b0;
            r_pcount  <= '0;
        end else begin
            r_index   <= n_index;
            r_crc     <= n_crc;
            r_tail0   <= n_tail0;
            r_tail1   <= n_tail1;
            r_proto   <= n_proto;
            r_flag_ok <= n_flag_ok;
            r_hdr_ok  <= n_hdr_ok;
            r_pcount  <= n_pcount;
        end
    end

endmodule
`default_nettype wire

[rtl/pfr_out_stage.sv]
// Result register that holds one result until the downstream side takes it.
`default_nettype none
module pfr_out_stage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire pfr_pkg::t_result i_result,
    input  wire logic             i_ready,
    output logic                  o_free,
    output logic                  o_valid,
    output pfr_pkg::t_result      o_result
);

    logic             r_valid;
    pfr_pkg::t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

endmodule
`default_nettype wire
